[hdl/source_text_tokenizer_assert.svh]
// Assertion macros used by the port-level checker of the source text tokenizer.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// Types, character codes and keyword tables of the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int TOK_LEN_W = 10;
  localparam int LINE_W    = 16;

  typedef enum logic [3:0] {
    KIND_END    = 4'd0,
    KIND_CHAR   = 4'd1,
    KIND_INT    = 4'd2,
    KIND_FLOAT  = 4'd3,
    KIND_IF     = 4'd4,
    KIND_FUNC   = 4'd5,
    KIND_IDENT  = 4'd6,
    KIND_NUMBER = 4'd7,
    KIND_STRING = 4'd8,
    KIND_EQEQ   = 4'd9,
    KIND_NEQ    = 4'd10
  } stt_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_STRING  = 2'd1,
    ERR_COMMENT = 2'd2
  } stt_err_t;

  // One token as it leaves the block.
  typedef struct packed {
    stt_kind_t             kind;
    logic [7:0]            code;
    logic [TOK_LEN_W-1:0]  len;
    logic [LINE_W-1:0]     line;
    stt_err_t              err;
    logic                  last;
  } stt_tok_t;

  // Tokens produced by one source byte, in order.
  typedef struct packed {
    logic [1:0] n;
    stt_tok_t   t0;
    stt_tok_t   t1;
  } stt_push_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [LINE_W-1:0] LINE_FIRST = 16'd1;
  localparam logic [LINE_W-1:0] LINE_SAT   = 16'hFFFF;

  // Keyword index k: 0 int, 1 float, 2 if, 3 function.
  function automatic logic [3:0] kw_len(input logic [1:0] k);
    logic [3:0] l;
    unique case (k)
      2'd0:    l = 4'd3;
      2'd1:    l = 4'd5;
      2'd2:    l = 4'd2;
      default: l = 4'd8;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
    logic [63:0] s;
    logic [2:0]  slot;
    unique case (k)
      2'd0:    s = {"int", 40'd0};
      2'd1:    s = {"float", 24'd0};
      2'd2:    s = {"if", 48'd0};
      default: s = "function";
    endcase
    slot = 3'd7 - i;
    return s[{slot, 3'b000} +: 8];
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

endpackage

[hdl/stt_scan.sv]
// ----------------------------------------------------------------------------
// stt_scan
// Scanner state and the one-byte step that updates it and forms tokens.
// ----------------------------------------------------------------------------
module stt_scan #(
  parameter int MAX_TOKEN_LEN = 1023
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        ch,
  output stt_pkg::stt_push_t push
);
  import stt_pkg::*;

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);

  typedef enum logic [9:0] {
    MODE_IDLE     = 10'b00_0000_0001,
    MODE_IDENT    = 10'b00_0000_0010,
    MODE_NUMBER   = 10'b00_0000_0100,
    MODE_STRING   = 10'b00_0000_1000,
    MODE_SLASH    = 10'b00_0001_0000,
    MODE_EQ       = 10'b00_0010_0000,
    MODE_BANG     = 10'b00_0100_0000,
    MODE_LCOMMENT = 10'b00_1000_0000,
    MODE_BCOMMENT = 10'b01_0000_0000,
    MODE_BSTAR    = 10'b10_0000_0000
  } scan_mode_t;

  scan_mode_t         mode_r, mode_nxt, idle_mode;
  logic [LINE_W-1:0]  line_r, line_nxt, idle_line, line_inc;
  logic [LEN_W-1:0]   len_r, len_nxt, idle_len;
  logic [3:0]         kw_r, kw_nxt, idle_kw;
  logic               a_v, idle_v;
  stt_tok_t           a_tok, idle_tok, t0, t1;
  logic [TOK_LEN_W-1:0] len_out;
  logic [LEN_W+TOK_LEN_W-1:0] len_wide;

  function automatic logic [LEN_W-1:0] grow(input logic [LEN_W-1:0] l);
    return (l != LEN_MAX) ? l + LEN_W'(1) : l;
  endfunction

  function automatic logic [3:0] kw_update(input logic [3:0] alive,
                                           input logic [LEN_W-1:0] l,
                                           input logic [7:0] c);
    logic [3:0] a;
    a = alive;
    for (int k = 0; k < 4; k++) begin
      if (l >= LEN_W'(kw_len(2'(k))) || kw_char(2'(k), l[2:0]) != c) begin
        a[k] = 1'b0;
      end
    end
    return a;
  endfunction

  function automatic stt_kind_t ident_kind(input logic [3:0] alive,
                                           input logic [LEN_W-1:0] l);
    stt_kind_t kd;
    kd = KIND_IDENT;
    // Walk down so that the lowest matching keyword wins.
    for (int k = 3; k >= 0; k--) begin
      if (alive[k] && l == LEN_W'(kw_len(2'(k)))) begin
        kd = stt_kind_t'(4'(2 + k));
      end
    end
    return kd;
  endfunction

  function automatic stt_tok_t mk_tok(input stt_kind_t kd, input logic [7:0] c,
                                      input logic [TOK_LEN_W-1:0] l,
                                      input stt_err_t e,
                                      input logic [LINE_W-1:0] ln);
    stt_tok_t t;
    t.kind = kd;
    t.code = c;
    t.len  = l;
    t.line = ln;
    t.err  = e;
    t.last = 1'b0;
    return t;
  endfunction

  assign len_wide = {{TOK_LEN_W{1'b0}}, len_r};
  assign len_out  = len_wide[TOK_LEN_W-1:0];
  assign line_inc = (line_r != LINE_SAT) ? line_r + LINE_W'(1) : line_r;

  // Scan of a byte from the idle mode, on the current registers.
  always_comb begin
    idle_mode = MODE_IDLE;
    idle_line = line_r;
    idle_len  = len_r;
    idle_kw   = kw_r;
    idle_v    = 1'b0;
    idle_tok  = mk_tok(KIND_END, CH_NUL, '0, ERR_NONE, line_r);
    if (ch == CH_NUL) begin
      idle_v    = 1'b1;
      idle_line = LINE_FIRST;
      idle_len  = '0;
      idle_kw   = 4'hF;
    end else if (ch <= CH_SPACE || ch[7]) begin
      if (ch == CH_LF) begin
        idle_line = line_inc;
      end
    end else begin
      idle_len = '0;
      idle_kw  = 4'hF;
      priority if (ch == CH_QUOTE) begin
        idle_mode = MODE_STRING;
      end else if (is_alpha(ch)) begin
        idle_mode = MODE_IDENT;
        idle_kw   = kw_update(4'hF, '0, ch);
        idle_len  = grow('0);
      end else if (is_digit(ch)) begin
        idle_mode = MODE_NUMBER;
        idle_len  = grow('0);
      end else if (ch == CH_SLASH) begin
        idle_mode = MODE_SLASH;
      end else if (ch == CH_EQ) begin
        idle_mode = MODE_EQ;
      end else if (ch == CH_BANG) begin
        idle_mode = MODE_BANG;
      end else begin
        idle_v   = 1'b1;
        idle_tok = mk_tok(KIND_CHAR, ch, '0, ERR_NONE, line_r);
      end
    end
  end

  // Mode-specific step; a byte that ends a pending token is rescanned as idle.
  always_comb begin
    logic use_idle;
    use_idle = 1'b0;
    mode_nxt = mode_r;
    line_nxt = line_r;
    len_nxt  = len_r;
    kw_nxt   = kw_r;
    a_v      = 1'b0;
    a_tok    = mk_tok(KIND_END, CH_NUL, '0, ERR_NONE, line_r);
    unique case (mode_r)
      MODE_IDENT: begin
        if (is_alpha(ch) || is_digit(ch)) begin
          kw_nxt  = kw_update(kw_r, len_r, ch);
          len_nxt = grow(len_r);
        end else begin
          a_v      = 1'b1;
          a_tok    = mk_tok(ident_kind(kw_r, len_r), CH_NUL, len_out, ERR_NONE, line_r);
          use_idle = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(ch) || ch == CH_DOT) begin
          len_nxt = grow(len_r);
        end else begin
          a_v      = 1'b1;
          a_tok    = mk_tok(KIND_NUMBER, CH_NUL, len_out, ERR_NONE, line_r);
          use_idle = 1'b1;
        end
      end
      MODE_STRING: begin
        if (ch == CH_QUOTE) begin
          a_v      = 1'b1;
          a_tok    = mk_tok(KIND_STRING, CH_NUL, len_out, ERR_NONE, line_r);
          mode_nxt = MODE_IDLE;
        end else if (ch == CH_NUL || ch == CH_CR || ch == CH_LF) begin
          a_v      = 1'b1;
          a_tok    = mk_tok(KIND_STRING, CH_NUL, len_out, ERR_STRING, line_r);
          use_idle = 1'b1;
        end else begin
          len_nxt = grow(len_r);
        end
      end
      MODE_SLASH: begin
        if (ch == CH_STAR) begin
          mode_nxt = MODE_BCOMMENT;
        end else if (ch == CH_SLASH) begin
          mode_nxt = MODE_LCOMMENT;
        end else begin
          a_v      = 1'b1;
          a_tok    = mk_tok(KIND_CHAR, CH_SLASH, '0, ERR_NONE, line_r);
          use_idle = 1'b1;
        end
      end
      MODE_EQ, MODE_BANG: begin
        if (ch == CH_EQ) begin
          a_v      = 1'b1;
          a_tok    = mk_tok((mode_r == MODE_EQ) ? KIND_EQEQ : KIND_NEQ, CH_NUL, '0,
                            ERR_NONE, line_r);
          mode_nxt = MODE_IDLE;
        end else begin
          a_v      = 1'b1;
          a_tok    = mk_tok(KIND_CHAR, (mode_r == MODE_EQ) ? CH_EQ : CH_BANG, '0,
                            ERR_NONE, line_r);
          use_idle = 1'b1;
        end
      end
      MODE_LCOMMENT: begin
        if (ch == CH_NUL || ch == CH_LF || ch == CH_CR) begin
          use_idle = 1'b1;
        end
      end
      MODE_BCOMMENT, MODE_BSTAR: begin
        if (ch == CH_NUL) begin
          a_v      = 1'b1;
          a_tok    = mk_tok(KIND_END, CH_NUL, '0, ERR_COMMENT, line_r);
          mode_nxt = MODE_IDLE;
          line_nxt = LINE_FIRST;
          len_nxt  = '0;
          kw_nxt   = 4'hF;
        end else if (ch == CH_STAR) begin
          mode_nxt = MODE_BSTAR;
        end else if (ch == CH_SLASH && mode_r == MODE_BSTAR) begin
          mode_nxt = MODE_IDLE;
        end else begin
          if (ch == CH_LF) begin
            line_nxt = line_inc;
          end
          mode_nxt = MODE_BCOMMENT;
        end
      end
      default: begin
        use_idle = 1'b1;
      end
    endcase
    if (use_idle) begin
      mode_nxt = idle_mode;
      line_nxt = idle_line;
      len_nxt  = idle_len;
      kw_nxt   = idle_kw;
    end
    t0      = a_v ? a_tok : idle_tok;
    t1      = idle_tok;
    t1.last = 1'b1;
    push.n  = '0;
    if (step) begin
      push.n = {1'b0, a_v} + {1'b0, idle_v && use_idle};
    end
    t0.last = (push.n != 2'd2);
    push.t0 = t0;
    push.t1 = t1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      line_r <= LINE_FIRST;
      len_r  <= '0;
      kw_r   <= 4'hF;
    end else if (step) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      len_r  <= len_nxt;
      kw_r   <= kw_nxt;
    end
  end

endmodule

[hdl/stt_outq.sv]
// ----------------------------------------------------------------------------
// stt_outq
// Four-entry token queue: takes up to two tokens a cycle, gives one.
// ----------------------------------------------------------------------------
module stt_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  stt_pkg::stt_push_t push,
  input  logic               pop,
  output stt_pkg::stt_tok_t  head,
  output logic               not_empty,
  output logic               room
);
  import stt_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  stt_tok_t        q_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign wr_ptr_p1  = wr_ptr_r + AW'(1);
  assign wr_ptr_nxt = wr_ptr_r + AW'(push.n);
  assign rd_ptr_nxt = rd_ptr_r + AW'(pop);
  assign cnt_nxt    = cnt_r + CW'(push.n) - CW'(pop);

  assign head      = q_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  // Room for the two tokens that one byte can produce.
  assign room      = (cnt_r <= CW'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[wr_ptr_r] <= push.t0;
    end
    if (push.n == 2'd2) begin
      q_r[wr_ptr_p1] <= push.t1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[hdl/source_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexical scanner for a small C-like language.
// ----------------------------------------------------------------------------
// The block takes one source byte per request on the in_ channel and returns
// tokens on the out_ channel: the keywords int, float, if and function,
// identifiers, numbers, quoted strings, == and !=, single-character tokens,
// and an end token when byte 0 arrives. Whitespace and line and block
// comments produce nothing. A byte is taken whenever the result queue has
// room for two tokens, so a continuous stream runs at one byte per cycle
// while that room lasts. The output side delivers one token per cycle while
// out_ready is high; a byte that closes one pending token and starts another
// (for example "a;" or "=;") yields two tokens, and the four-entry result
// queue absorbs that burst, so the sustained input rate drops below one byte
// per cycle only when two-token bytes dominate. A token is visible on the
// outputs at the earliest in the cycle after the byte that completes it is
// accepted. out_last marks the final token produced by a given byte.
// After an end token all scanner state returns to its reset values, so the
// next byte begins a new text at line 1. No initialization pass is needed
// after reset.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
  parameter int MAX_TOKEN_LEN = 1023
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_token_kind,
  output logic [7:0]  out_char_code,
  output logic [9:0]  out_token_length,
  output logic [15:0] out_line_number,
  output logic [1:0]  out_error_code,
  output logic        out_last
);
  import stt_pkg::*;

  logic      in_fire;
  logic      out_fire;
  stt_push_t push;
  stt_tok_t  head;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // The scanner advances its mode, line count, token length and keyword
  // match flags only on an accepted request.
  stt_scan #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .step (in_fire),
    .ch   (in_ch),
    .push (push)
  );

  // Result queue; its ready depends only on registered occupancy.
  stt_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (out_fire),
    .head     (head),
    .not_empty(out_valid),
    .room     (in_ready)
  );

  assign out_token_kind   = head.kind;
  assign out_char_code    = head.code;
  assign out_token_length = head.len;
  assign out_line_number  = head.line;
  assign out_error_code   = head.err;
  assign out_last         = head.last;

endmodule

[hdl/stt_chk.sv]
// ----------------------------------------------------------------------------
// stt_chk
// Port-level checker for the source text tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_assert.svh"

module stt_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_token_kind,
  input logic [7:0]  out_char_code,
  input logic [9:0]  out_token_length,
  input logic [15:0] out_line_number,
  input logic [1:0]  out_error_code
);
  import stt_pkg::*;

  // A stalled token must hold until it is taken.
  `STT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_token_kind) && $stable(out_line_number) && $stable(out_token_length), "token changed while stalled")

  // Errors only come with an unterminated string or a cut-off block comment.
  `STT_ASSERT_NOW(a_err_kind, out_valid && out_error_code != ERR_NONE, (out_error_code == ERR_STRING && out_token_kind == KIND_STRING) || (out_error_code == ERR_COMMENT && out_token_kind == KIND_END), "error code on wrong token kind")

  // Only single-character tokens carry a character code.
  `STT_ASSERT_NOW(a_char_only, out_valid && out_token_kind != KIND_CHAR, out_char_code == 8'd0, "char code on non-char token")

  // Tokens without text have zero length, and lines count from one.
  `STT_ASSERT_NOW(a_len_line, out_valid && (out_token_kind == KIND_END || out_token_kind == KIND_CHAR || out_token_kind == KIND_EQEQ || out_token_kind == KIND_NEQ), out_token_length == 10'd0 && out_line_number != 16'd0, "bad length or line on token")

endmodule

bind source_text_tokenizer stt_chk u_stt_chk (.*);

[tb/source_text_tokenizer_checker.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer_checker
// Watches both channels of the tokenizer, predicts its tokens and compares.
// ----------------------------------------------------------------------------
// Every accepted source byte is run through a scanner model of its own, and
// the tokens it completes are queued in order. Every accepted token is
// compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module source_text_tokenizer_checker #(
  parameter int MAX_LEN = 1023
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_ch,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_token_kind,
  input  logic [7:0]  out_char_code,
  input  logic [9:0]  out_token_length,
  input  logic [15:0] out_line_number,
  input  logic [1:0]  out_error_code,
  input  logic        out_last,
  output int          token_errors,
  output int          tokens_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import stt_pkg::*;

  typedef enum logic [3:0] {
    SC_IDLE, SC_WORD, SC_NUM, SC_STR, SC_SLASH, SC_EQ, SC_BANG,
    SC_LINE_CMT, SC_BLOCK_CMT, SC_BLOCK_STAR
  } scan_t;

  string kw_word [4] = '{"int", "float", "if", "function"};

  scan_t       mode;
  logic [15:0] cur_line;
  logic [9:0]  tok_len;
  logic [3:0]  kw_live;
  stt_tok_t    step_toks [$];
  stt_tok_t    token_fifo [$];
  int          mismatches = 0;

  function automatic logic letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic logic numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void reset_scanner();
    mode     = SC_IDLE;
    cur_line = LINE_FIRST;
    tok_len  = '0;
    kw_live  = 4'hF;
  endfunction

  function automatic void push_tok(stt_kind_t kind, logic [7:0] code, logic [9:0] len,
                                   stt_err_t err);
    stt_tok_t t;
    t.kind = kind;
    t.code = code;
    t.len  = len;
    t.line = cur_line;
    t.err  = err;
    t.last = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void bump_line();
    if (cur_line != LINE_SAT) cur_line = cur_line + 1'b1;
  endfunction

  function automatic void grow_len();
    if (tok_len < MAX_LEN) tok_len = tok_len + 1'b1;
  endfunction

  // A keyword stays alive only while every character so far matches it.
  function automatic void word_add(logic [7:0] c);
    int k;
    for (k = 0; k < 4; k++) begin
      if (tok_len >= kw_word[k].len() || kw_word[k][tok_len] != c) kw_live[k] = 1'b0;
    end
    grow_len();
  endfunction

  function automatic void word_finish();
    stt_kind_t kind;
    int k;
    kind = KIND_IDENT;
    for (k = 3; k >= 0; k--) begin
      if (kw_live[k] && tok_len == kw_word[k].len()) kind = stt_kind_t'(KIND_INT + k);
    end
    push_tok(kind, 8'd0, tok_len, ERR_NONE);
  endfunction

  // Scanning from the idle mode, also used for a byte that closed a token.
  function automatic void scan_fresh(logic [7:0] c);
    mode = SC_IDLE;
    if (c == CH_NUL) begin
      push_tok(KIND_END, 8'd0, 10'd0, ERR_NONE);
      reset_scanner();
    end else if (c <= CH_SPACE || c >= 8'h80) begin
      if (c == CH_LF) bump_line();
    end else begin
      tok_len = '0;
      kw_live = 4'hF;
      if (c == CH_QUOTE) mode = SC_STR;
      else if (letter(c)) begin
        mode = SC_WORD;
        word_add(c);
      end else if (numeral(c)) begin
        mode = SC_NUM;
        grow_len();
      end else if (c == CH_SLASH) mode = SC_SLASH;
      else if (c == CH_EQ) mode = SC_EQ;
      else if (c == CH_BANG) mode = SC_BANG;
      else push_tok(KIND_CHAR, c, 10'd0, ERR_NONE);
    end
  endfunction

  function automatic void lex_byte(logic [7:0] c);
    int i;
    step_toks.delete();
    case (mode)
      SC_WORD: begin
        if (letter(c) || numeral(c)) word_add(c);
        else begin
          word_finish();
          scan_fresh(c);
        end
      end
      SC_NUM: begin
        if (numeral(c) || c == CH_DOT) grow_len();
        else begin
          push_tok(KIND_NUMBER, 8'd0, tok_len, ERR_NONE);
          scan_fresh(c);
        end
      end
      SC_STR: begin
        if (c == CH_QUOTE) begin
          push_tok(KIND_STRING, 8'd0, tok_len, ERR_NONE);
          mode = SC_IDLE;
        end else if (c == CH_NUL || c == CH_CR || c == CH_LF) begin
          push_tok(KIND_STRING, 8'd0, tok_len, ERR_STRING);
          scan_fresh(c);
        end else grow_len();
      end
      SC_SLASH: begin
        if (c == CH_STAR) mode = SC_BLOCK_CMT;
        else if (c == CH_SLASH) mode = SC_LINE_CMT;
        else begin
          push_tok(KIND_CHAR, CH_SLASH, 10'd0, ERR_NONE);
          scan_fresh(c);
        end
      end
      SC_EQ, SC_BANG: begin
        if (c == CH_EQ) begin
          push_tok(mode == SC_EQ ? KIND_EQEQ : KIND_NEQ, 8'd0, 10'd0, ERR_NONE);
          mode = SC_IDLE;
        end else begin
          push_tok(KIND_CHAR, mode == SC_EQ ? CH_EQ : CH_BANG, 10'd0, ERR_NONE);
          scan_fresh(c);
        end
      end
      SC_LINE_CMT: begin
        if (c == CH_NUL || c == CH_LF || c == CH_CR) scan_fresh(c);
      end
      SC_BLOCK_CMT, SC_BLOCK_STAR: begin
        if (c == CH_NUL) begin
          push_tok(KIND_END, 8'd0, 10'd0, ERR_COMMENT);
          reset_scanner();
        end else if (c == CH_STAR) mode = SC_BLOCK_STAR;
        else if (c == CH_SLASH && mode == SC_BLOCK_STAR) mode = SC_IDLE;
        else begin
          if (c == CH_LF) bump_line();
          mode = SC_BLOCK_CMT;
        end
      end
      default: scan_fresh(c);
    endcase
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    for (i = 0; i < step_toks.size(); i++) token_fifo.push_back(step_toks[i]);
  endfunction

  always @(posedge clk) begin
    stt_tok_t want;
    if (!rst_n) begin
      reset_scanner();
      token_fifo.delete();
    end else begin
      if (in_valid && in_ready) lex_byte(in_ch);
      if (out_valid && out_ready) begin
        if (token_fifo.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: unexpected token kind=%0d code=%0d len=%0d line=%0d err=%0d",
                     $realtime, out_token_kind, out_char_code, out_token_length,
                     out_line_number, out_error_code);
        end else begin
          want = token_fifo.pop_front();
          if (out_token_kind !== want.kind || out_char_code !== want.code ||
              out_token_length !== want.len || out_line_number !== want.line ||
              out_error_code !== want.err || out_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%t: token mismatch", $realtime);
              $display("  expected kind=%0d code=%0d len=%0d line=%0d err=%0d last=%0d",
                       want.kind, want.code, want.len, want.line, want.err, want.last);
              $display("  actual   kind=%0d code=%0d len=%0d line=%0d err=%0d last=%0d",
                       out_token_kind, out_char_code, out_token_length, out_line_number,
                       out_error_code, out_last);
            end
          end
        end
      end
    end
    tokens_pending <= token_fifo.size();
    token_errors   <= mismatches;
  end

endmodule

[tb/tb_source_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// tb_source_text_tokenizer
// Stimulus and verdict for the source text tokenizer.
// ----------------------------------------------------------------------------
// Source bytes are offered on the in_ channel in three phases with different
// idling on both sides. The first opens with a short directed text with the
// special cases and a receiver hold-off that backs the block up; every phase
// sends random fragments of C-like text. A separate checker predicts and compares every token.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import stt_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int HOLD_CYCLES = 80;    // long receiver hold-off
  localparam int TAIL_CYCLES = 10;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  in_ch     = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_token_kind;
  logic [7:0]  out_char_code;
  logic [9:0]  out_token_length;
  logic [15:0] out_line_number;
  logic [1:0]  out_error_code;
  logic        out_last;

  int token_errors;
  int tokens_pending;

  // Idle percentages of the two sides; the receiver's is read by its own process.
  int send_idle = 0;
  int recv_idle = 0;
  int bytes_sent = 0;

  // The stimulus process asks for a hold-off by flipping hold_toggle.
  logic hold_toggle = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_left   = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  source_text_tokenizer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ch            (in_ch),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_char_code    (out_char_code),
    .out_token_length (out_token_length),
    .out_line_number  (out_line_number),
    .out_error_code   (out_error_code),
    .out_last         (out_last)
  );

  source_text_tokenizer_checker u_token_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ch            (in_ch),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_char_code    (out_char_code),
    .out_token_length (out_token_length),
    .out_line_number  (out_line_number),
    .out_error_code   (out_error_code),
    .out_last         (out_last),
    .token_errors     (token_errors),
    .tokens_pending   (tokens_pending)
  );

  // Receiver: random stalls, or a counted hold-off when one is requested.
  // Only one assignment to out_ready is made per clock edge.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_toggle != hold_seen) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_toggle;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Offers one byte and returns at the edge that accepts it. An idle gap
  // lowers valid first; once raised, valid stays up with the byte unchanged.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle = sender_pct;
    recv_idle <= receiver_pct;
  endtask

  // Lowers valid and waits until every predicted token has come out. The
  // checker's count is registered, so the task first waits for a clock edge.
  task automatic drain(input int limit);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens_pending != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // Identifier characters; a leading one may not be a digit.
  function automatic logic [7:0] word_char(input bit lead);
    int r;
    r = $urandom_range(lead ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return CH_UNDER;
    return 8'("0" + r - 53);
  endfunction

  // Any nonzero byte except the line breaks and, inside strings, the quote.
  function automatic logic [7:0] body_byte(input bit no_quote);
    logic [7:0] b;
    do b = 8'($urandom_range(255, 1));
    while (b == CH_LF || b == CH_CR || (no_quote && b == CH_QUOTE));
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    if ($urandom_range(1)) return 8'($urandom_range(32, 1));
    return 8'($urandom_range(255, 128));
  endfunction

  // One random piece of source text. Most pieces are well formed so that
  // keywords, strings and comments are reached; the rest is noise, broken
  // pieces and the end byte, which also cuts pieces off in any mode.
  task automatic send_fragment();
    int    pick, n, i;
    string kw;
    logic [7:0] follow [7];
    follow = '{CH_EQ, CH_SLASH, CH_STAR, "a", CH_SPACE, ";", CH_BANG};
    pick = $urandom_range(99);
    if (pick < 15) begin
      // Keywords, their prefixes and their extensions.
      case ($urandom_range(3))
        0: kw = "int";
        1: kw = "float";
        2: kw = "if";
        default: kw = "function";
      endcase
      n = kw.len();
      if ($urandom_range(3) == 0) n = $urandom_range(kw.len(), 1);
      send_text(kw.substr(0, n - 1));
      if ($urandom_range(3) == 0) repeat ($urandom_range(3, 1)) send_byte(word_char(1'b0));
    end else if (pick < 27) begin
      send_byte(word_char(1'b1));
      repeat ($urandom_range(10)) send_byte(word_char(1'b0));
    end else if (pick < 37) begin
      send_byte(8'("0" + $urandom_range(9)));
      repeat ($urandom_range(6)) begin
        if ($urandom_range(3) == 0) send_byte(CH_DOT);
        else send_byte(8'("0" + $urandom_range(9)));
      end
    end else if (pick < 47) begin
      send_byte(CH_QUOTE);
      repeat ($urandom_range(8)) send_byte(body_byte(1'b1));
      case ($urandom_range(19))
        0: send_byte(CH_LF);
        1: send_byte(CH_CR);
        2: send_byte(CH_NUL);
        default: send_byte(CH_QUOTE);
      endcase
    end else if (pick < 60) begin
      // A held slash, equals or bang and whatever comes next.
      case ($urandom_range(2))
        0: send_byte(CH_SLASH);
        1: send_byte(CH_EQ);
        default: send_byte(CH_BANG);
      endcase
      send_byte(follow[$urandom_range(6)]);
    end else if (pick < 68) begin
      send_byte(8'($urandom_range(126, 33)));
    end else if (pick < 74) begin
      send_byte(CH_SLASH);
      send_byte(CH_SLASH);
      repeat ($urandom_range(10)) send_byte(body_byte(1'b0));
      case ($urandom_range(9))
        0: send_byte(CH_NUL);
        1, 2, 3: send_byte(CH_CR);
        default: send_byte(CH_LF);
      endcase
    end else if (pick < 81) begin
      send_byte(CH_SLASH);
      send_byte(CH_STAR);
      n = $urandom_range(10);
      for (i = 0; i < n; i++) begin
        case ($urandom_range(4))
          0: send_byte(CH_STAR);
          1: send_byte(CH_SLASH);
          2: send_byte(CH_LF);
          default: send_byte(body_byte(1'b0));
        endcase
      end
      if ($urandom_range(9) == 0) send_byte(CH_NUL);
      else begin
        send_byte(CH_STAR);
        send_byte(CH_SLASH);
      end
    end else if (pick < 93) begin
      repeat ($urandom_range(3, 1)) send_byte(blank_byte());
    end else if (pick < 97) begin
      send_byte(8'($urandom_range(255, 1)));
    end else begin
      send_byte(CH_NUL);
    end
  endtask

  task automatic send_random_text(input int count);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < count) send_fragment();
  endtask

  // Opening text: an unterminated string cut by a newline, lone equals,
  // bang and slash falling back to single characters (the slash then gives
  // two tokens at once), the two-character operators, the byte extremes
  // around the whitespace ranges, an unterminated block comment and an
  // unterminated string both ended by the end byte, and a number cut by CR.
  logic [7:0] opening [] = '{
    CH_QUOTE, "a", "b", CH_LF,
    CH_EQ, "x", CH_BANG, CH_SLASH, ";",
    CH_EQ, CH_EQ, CH_BANG, CH_EQ,
    8'h7F, 8'h80, 8'hFF, 8'h01, CH_SPACE,
    CH_SLASH, CH_STAR, CH_NUL,
    CH_QUOTE, CH_NUL,
    "9", CH_DOT, CH_CR
  };

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: the sender idles a little, the receiver a lot.
    set_idling(21, 64);
    foreach (opening[i]) send_byte(opening[i]);

    // Hold the receiver off while two-token pairs keep coming, so the
    // result queue fills up and the block has to refuse requests.
    hold_toggle <= ~hold_toggle;
    repeat (30) send_text("x;");
    send_random_text(250);
    drain(20000);

    // Phase two: the other way round.
    set_idling(64, 21);
    send_random_text(250);
    drain(20000);

    // Phase three: no idling on either side.
    set_idling(0, 0);
    send_random_text(250);

    drain(20000);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tokens_pending != 0) $display("%0d predicted tokens never came out", tokens_pending);
    if (token_errors == 0 && tokens_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
